// ===== design/rsdz_pkg.sv =====
// Package for the radial stick dead zone core: field widths, fixed-point constants
// and reset values. No dependencies.
package rsdz_pkg;

    localparam int RAW_W     = 16;
    localparam int RADIUS_W  = 15;
    localparam int SQ_W      = 31;
    localparam int SUMSQ_W   = 32;
    localparam int RAD_SQ_W  = 30;
    localparam int FRAC_W    = 8;
    localparam int ROOT_IN_W = SUMSQ_W + 2 * FRAC_W;
    localparam int ROOT_W    = ROOT_IN_W / 2;
    localparam int MAG_W     = 23;
    localparam int NUMK_W    = ROOT_W + RADIUS_W;
    localparam int PROD_W    = RAW_W + MAG_W;
    localparam int AXIS_Q_W  = 15;
    localparam int OUT_W     = 16;

    localparam logic [RADIUS_W-1:0] FULL_SCALE    = 15'd32767;
    localparam logic [MAG_W-1:0]    MAG_CAP       = 23'd8388352;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET  = 15'd9830;
    localparam logic [RAD_SQ_W-1:0] RAD_SQ_RESET  = 30'd96628900;
    localparam logic [AXIS_Q_W-1:0] AXIS_MAX      = 15'd32767;

endpackage

// ===== design/rsdz_isqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
// Generic; carries a side payload and a valid bit alongside the operand.
module rsdz_isqrt #(
    parameter int IN_W  = 48,
    parameter int TAG_W = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [IN_W-1:0]       in_value,
    input  logic [TAG_W-1:0]      in_tag,
    output logic                  out_valid,
    output logic [IN_W/2-1:0]     out_root,
    output logic [TAG_W-1:0]      out_tag
);

    localparam int OUT_W = IN_W / 2;
    localparam int REM_W = OUT_W + 3;

    logic              valid_reg [OUT_W];
    logic [REM_W-1:0]  rem_reg   [OUT_W];
    logic [OUT_W-1:0]  root_reg  [OUT_W];
    logic [IN_W-1:0]   bits_reg  [OUT_W];
    logic [TAG_W-1:0]  tag_reg   [OUT_W];

    for (genvar k = 0; k < OUT_W; k++)
    begin : g_stage
        logic              valid_in;
        logic [REM_W-1:0]  rem_in;
        logic [OUT_W-1:0]  root_in;
        logic [IN_W-1:0]   bits_in;
        logic [TAG_W-1:0]  tag_in;
        logic [REM_W-1:0]  trial;
        logic [REM_W-1:0]  test;
        logic              take;
        logic [REM_W-1:0]  rem_next;
        logic [OUT_W-1:0]  root_next;

        if (k == 0)
        begin : g_first
            assign valid_in = in_valid;
            assign rem_in   = '0;
            assign root_in  = '0;
            assign bits_in  = in_value;
            assign tag_in   = in_tag;
        end
        else
        begin : g_next
            assign valid_in = valid_reg[k-1];
            assign rem_in   = rem_reg[k-1];
            assign root_in  = root_reg[k-1];
            assign bits_in  = bits_reg[k-1];
            assign tag_in   = tag_reg[k-1];
        end

        assign trial     = {rem_in[REM_W-3:0], bits_in[IN_W-1 -: 2]};
        assign test      = {1'b0, root_in, 2'b01};
        assign take      = (trial >= test);
        assign rem_next  = take ? (trial - test) : trial;
        assign root_next = {root_in[OUT_W-2:0], take};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                bits_reg[k] <= {bits_in[IN_W-3:0], 2'b00};
                tag_reg[k]  <= tag_in;
            end
        end
    end

    assign out_valid = valid_reg[OUT_W-1];
    assign out_root  = root_reg[OUT_W-1];
    assign out_tag   = tag_reg[OUT_W-1];

endmodule

// ===== design/rsdz_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage, with a
// saturation flag for quotients that do not fit. Generic; no package needed.
module rsdz_div #(
    parameter int NUM_W = 39,
    parameter int DEN_W = 15,
    parameter int Q_W   = 23,
    parameter int TAG_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [TAG_W-1:0]  in_tag,
    output logic              out_valid,
    output logic [Q_W-1:0]    out_quot,
    output logic              out_sat,
    output logic [TAG_W-1:0]  out_tag
);

    localparam int HI_W  = NUM_W - Q_W;
    localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic              valid_reg [Q_W];
    logic [NUM_W-1:0]  rem_reg   [Q_W];
    logic [DEN_W-1:0]  den_reg   [Q_W];
    logic [Q_W-1:0]    quot_reg  [Q_W];
    logic              sat_reg   [Q_W];
    logic [TAG_W-1:0]  tag_reg   [Q_W];

    logic [CMP_W-1:0]  num_hi;
    logic [CMP_W-1:0]  den_ext;
    logic              sat_first;

    // The quotient overflows Q_W bits exactly when num / 2^Q_W >= den.
    assign num_hi    = CMP_W'(in_num[NUM_W-1:Q_W]);
    assign den_ext   = CMP_W'(in_den);
    assign sat_first = (num_hi >= den_ext);

    for (genvar k = 0; k < Q_W; k++)
    begin : g_stage
        localparam int J = Q_W - 1 - k;

        logic              valid_in;
        logic [NUM_W-1:0]  rem_in;
        logic [DEN_W-1:0]  den_in;
        logic [Q_W-1:0]    quot_in;
        logic              sat_in;
        logic [TAG_W-1:0]  tag_in;
        logic [NUM_W-1:0]  den_shift;
        logic              take;
        logic [NUM_W-1:0]  rem_next;

        if (k == 0)
        begin : g_first
            assign valid_in = in_valid;
            assign rem_in   = in_num;
            assign den_in   = in_den;
            assign quot_in  = '0;
            assign sat_in   = sat_first;
            assign tag_in   = in_tag;
        end
        else
        begin : g_next
            assign valid_in = valid_reg[k-1];
            assign rem_in   = rem_reg[k-1];
            assign den_in   = den_reg[k-1];
            assign quot_in  = quot_reg[k-1];
            assign sat_in   = sat_reg[k-1];
            assign tag_in   = tag_reg[k-1];
        end

        assign den_shift = NUM_W'(den_in) << J;
        assign take      = (rem_in >= den_shift);
        assign rem_next  = take ? (rem_in - den_shift) : rem_in;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                den_reg[k]  <= den_in;
                quot_reg[k] <= {quot_in[Q_W-2:0], take};
                sat_reg[k]  <= sat_in;
                tag_reg[k]  <= tag_in;
            end
        end
    end

    assign out_valid = valid_reg[Q_W-1];
    assign out_quot  = quot_reg[Q_W-1];
    assign out_sat   = sat_reg[Q_W-1];
    assign out_tag   = tag_reg[Q_W-1];

endmodule

// ===== design/radial_stick_dead_zone_core.sv =====
// Top level of the scaled radial dead zone for one analog stick.
// Depends on rsdz_pkg, rsdz_isqrt and rsdz_div.
//
//   Channel  Direction  Signals                    Content
//   s_*      in         tvalid tready tdata[31:0]  raw_x, raw_y
//   m_*      out        tvalid tready tdata[31:0]  shaped_x, shaped_y
//   cfg_*    in         valid ready data[14:0]     dead_zone_radius
//
// One request enters per cycle while the output register is not held; each passes
// from input to output through the 24-stage square root, the 23-stage length divider
// and the 15-stage axis dividers. Reset clears all valid bits and loads radius 9830.
// When the output register holds a result that is not taken, the whole
// pipeline holds and s_tready is low; no request is lost or repeated.
module radial_stick_dead_zone_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // raw_x [15:0], raw_y [31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // shaped_x [15:0], shaped_y [31:16]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [14:0] cfg_data   // dead_zone_radius [14:0]
);

    localparam int RAW_W    = rsdz_pkg::RAW_W;
    localparam int RADIUS_W = rsdz_pkg::RADIUS_W;
    localparam int SQ_W     = rsdz_pkg::SQ_W;
    localparam int SUMSQ_W  = rsdz_pkg::SUMSQ_W;
    localparam int RAD_SQ_W = rsdz_pkg::RAD_SQ_W;
    localparam int FRAC_W   = rsdz_pkg::FRAC_W;
    localparam int ROOT_IN_W = rsdz_pkg::ROOT_IN_W;
    localparam int ROOT_W   = rsdz_pkg::ROOT_W;
    localparam int MAG_W    = rsdz_pkg::MAG_W;
    localparam int NUMK_W   = rsdz_pkg::NUMK_W;
    localparam int PROD_W   = rsdz_pkg::PROD_W;
    localparam int AXIS_Q_W = rsdz_pkg::AXIS_Q_W;
    localparam int OUT_W    = rsdz_pkg::OUT_W;
    localparam int SQRT_TAG_W = 1 + 2 * RAW_W;
    localparam int DIV1_TAG_W = 3 + 2 * RAW_W + ROOT_W;
    localparam int DIV2_TAG_W = 2;

    logic en;

    logic [RADIUS_W-1:0] radius_reg;
    logic [RAD_SQ_W-1:0] rad_sq_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= rsdz_pkg::RADIUS_RESET;
            rad_sq_reg <= rsdz_pkg::RAD_SQ_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            radius_reg <= cfg_data;
            rad_sq_reg <= RAD_SQ_W'(cfg_data) * RAD_SQ_W'(cfg_data);
        end
    end

    // Stage 1: squares of both axes.
    logic signed [RAW_W-1:0]   raw_x;
    logic signed [RAW_W-1:0]   raw_y;
    logic signed [2*RAW_W-1:0] x_sq_full;
    logic signed [2*RAW_W-1:0] y_sq_full;
    logic                      v1_reg;
    logic [RAW_W-1:0]          x1_reg;
    logic [RAW_W-1:0]          y1_reg;
    logic [SQ_W-1:0]           x_sq1_reg;
    logic [SQ_W-1:0]           y_sq1_reg;

    assign raw_x     = s_tdata[RAW_W-1:0];
    assign raw_y     = s_tdata[2*RAW_W-1:RAW_W];
    assign x_sq_full = raw_x * raw_x;
    assign y_sq_full = raw_y * raw_y;

    // Stage 2: sum of squares and the dead-zone test.
    logic [SUMSQ_W-1:0] sum_next;
    logic               zero_next;
    logic               v2_reg;
    logic [RAW_W-1:0]   x2_reg;
    logic [RAW_W-1:0]   y2_reg;
    logic [SUMSQ_W-1:0] sum2_reg;
    logic               zero2_reg;

    assign sum_next  = SUMSQ_W'(x_sq1_reg) + SUMSQ_W'(y_sq1_reg);
    assign zero_next = (sum_next < SUMSQ_W'(rad_sq_reg)) || (sum_next == '0);

    // Square root of the sum in Q.8 units.
    logic                  sq_valid;
    logic [ROOT_W-1:0]     sq_root;
    logic [SQRT_TAG_W-1:0] sq_tag;

    rsdz_isqrt #(
        .IN_W  (ROOT_IN_W),
        .TAG_W (SQRT_TAG_W)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v2_reg),
        .in_value  ({SUMSQ_W'(sum2_reg), (ROOT_IN_W - SUMSQ_W)'(0)}),
        .in_tag    ({zero2_reg, x2_reg, y2_reg}),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_tag   (sq_tag)
    );

    // Stage 3: length above the radius, times full scale; axis magnitudes.
    logic              sq_zero;
    logic [RAW_W-1:0]  sq_x;
    logic [RAW_W-1:0]  sq_y;
    logic [ROOT_W-1:0] excess;
    logic [RAW_W-1:0]  abs_x;
    logic [RAW_W-1:0]  abs_y;
    logic              v3_reg;
    logic [NUMK_W-1:0] numk3_reg;
    logic [ROOT_W-1:0] rq3_reg;
    logic [RAW_W-1:0]  ax3_reg;
    logic [RAW_W-1:0]  ay3_reg;
    logic              sx3_reg;
    logic              sy3_reg;
    logic              zero3_reg;

    assign sq_zero = sq_tag[SQRT_TAG_W-1];
    assign sq_x    = sq_tag[2*RAW_W-1:RAW_W];
    assign sq_y    = sq_tag[RAW_W-1:0];
    assign excess  = sq_root - ROOT_W'({radius_reg, FRAC_W'(0)});
    assign abs_x   = sq_x[RAW_W-1] ? (~sq_x + RAW_W'(1)) : sq_x;
    assign abs_y   = sq_y[RAW_W-1] ? (~sq_y + RAW_W'(1)) : sq_y;

    // Remapped length: excess * K / (K - radius); zero divisor saturates.
    logic                  d1_valid;
    logic [MAG_W-1:0]      d1_quot;
    logic                  d1_sat;
    logic [DIV1_TAG_W-1:0] d1_tag;

    rsdz_div #(
        .NUM_W (NUMK_W),
        .DEN_W (RADIUS_W),
        .Q_W   (MAG_W),
        .TAG_W (DIV1_TAG_W)
    ) u_div_mag (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v3_reg),
        .in_num    (numk3_reg),
        .in_den    (rsdz_pkg::FULL_SCALE - radius_reg),
        .in_tag    ({zero3_reg, sx3_reg, sy3_reg, ax3_reg, ay3_reg, rq3_reg}),
        .out_valid (d1_valid),
        .out_quot  (d1_quot),
        .out_sat   (d1_sat),
        .out_tag   (d1_tag)
    );

    // Stage 4: cap the remapped length.
    logic [MAG_W-1:0]  mag_next;
    logic              v4_reg;
    logic [MAG_W-1:0]  mag4_reg;
    logic [ROOT_W-1:0] rq4_reg;
    logic [RAW_W-1:0]  ax4_reg;
    logic [RAW_W-1:0]  ay4_reg;
    logic              sx4_reg;
    logic              sy4_reg;
    logic              zero4_reg;

    assign mag_next = (d1_sat || (d1_quot > rsdz_pkg::MAG_CAP)) ? rsdz_pkg::MAG_CAP : d1_quot;

    // Stage 5: axis magnitude times remapped length.
    logic              v5_reg;
    logic [PROD_W-1:0] px5_reg;
    logic [PROD_W-1:0] py5_reg;
    logic [ROOT_W-1:0] rq5_reg;
    logic              sx5_reg;
    logic              sy5_reg;
    logic              zero5_reg;

    // Stage 6: add half the divisor for round to nearest.
    logic              v6_reg;
    logic [PROD_W-1:0] nx6_reg;
    logic [PROD_W-1:0] ny6_reg;
    logic [ROOT_W-1:0] rq6_reg;
    logic              sx6_reg;
    logic              sy6_reg;
    logic              zero6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= sq_valid;
            v4_reg <= d1_valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg    <= raw_x;
            y1_reg    <= raw_y;
            x_sq1_reg <= x_sq_full[SQ_W-1:0];
            y_sq1_reg <= y_sq_full[SQ_W-1:0];

            x2_reg    <= x1_reg;
            y2_reg    <= y1_reg;
            sum2_reg  <= sum_next;
            zero2_reg <= zero_next;

            numk3_reg <= NUMK_W'(excess) * NUMK_W'(rsdz_pkg::FULL_SCALE);
            rq3_reg   <= sq_root;
            ax3_reg   <= abs_x;
            ay3_reg   <= abs_y;
            sx3_reg   <= sq_x[RAW_W-1];
            sy3_reg   <= sq_y[RAW_W-1];
            zero3_reg <= sq_zero;

            mag4_reg  <= mag_next;
            rq4_reg   <= d1_tag[ROOT_W-1:0];
            ay4_reg   <= d1_tag[ROOT_W +: RAW_W];
            ax4_reg   <= d1_tag[ROOT_W + RAW_W +: RAW_W];
            sy4_reg   <= d1_tag[ROOT_W + 2*RAW_W];
            sx4_reg   <= d1_tag[ROOT_W + 2*RAW_W + 1];
            zero4_reg <= d1_tag[ROOT_W + 2*RAW_W + 2];

            px5_reg   <= PROD_W'(ax4_reg) * PROD_W'(mag4_reg);
            py5_reg   <= PROD_W'(ay4_reg) * PROD_W'(mag4_reg);
            rq5_reg   <= rq4_reg;
            sx5_reg   <= sx4_reg;
            sy5_reg   <= sy4_reg;
            zero5_reg <= zero4_reg;

            nx6_reg   <= px5_reg + PROD_W'(rq5_reg >> 1);
            ny6_reg   <= py5_reg + PROD_W'(rq5_reg >> 1);
            rq6_reg   <= rq5_reg;
            sx6_reg   <= sx5_reg;
            sy6_reg   <= sy5_reg;
            zero6_reg <= zero5_reg;
        end
    end

    // Per-axis rounded division by the length.
    logic                  dx_valid;
    logic [AXIS_Q_W-1:0]   dx_quot;
    logic                  dx_sat;
    logic [DIV2_TAG_W-1:0] dx_tag;
    logic                  dy_valid;
    logic [AXIS_Q_W-1:0]   dy_quot;
    logic                  dy_sat;
    logic [DIV2_TAG_W-1:0] dy_tag;

    rsdz_div #(
        .NUM_W (PROD_W),
        .DEN_W (ROOT_W),
        .Q_W   (AXIS_Q_W),
        .TAG_W (DIV2_TAG_W)
    ) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v6_reg),
        .in_num    (nx6_reg),
        .in_den    (rq6_reg),
        .in_tag    ({zero6_reg, sx6_reg}),
        .out_valid (dx_valid),
        .out_quot  (dx_quot),
        .out_sat   (dx_sat),
        .out_tag   (dx_tag)
    );

    rsdz_div #(
        .NUM_W (PROD_W),
        .DEN_W (ROOT_W),
        .Q_W   (AXIS_Q_W),
        .TAG_W (DIV2_TAG_W)
    ) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v6_reg),
        .in_num    (ny6_reg),
        .in_den    (rq6_reg),
        .in_tag    ({zero6_reg, sy6_reg}),
        .out_valid (dy_valid),
        .out_quot  (dy_quot),
        .out_sat   (dy_sat),
        .out_tag   (dy_tag)
    );

    // Output register: clamp, sign and the dead-zone zero.
    logic [OUT_W-1:0] mag_x;
    logic [OUT_W-1:0] mag_y;
    logic [OUT_W-1:0] shaped_x_next;
    logic [OUT_W-1:0] shaped_y_next;
    logic             out_valid_reg;
    logic [OUT_W-1:0] shaped_x_reg;
    logic [OUT_W-1:0] shaped_y_reg;

    assign mag_x = {1'b0, dx_sat ? rsdz_pkg::AXIS_MAX : dx_quot};
    assign mag_y = {1'b0, dy_sat ? rsdz_pkg::AXIS_MAX : dy_quot};
    assign shaped_x_next = dx_tag[1] ? '0 : (dx_tag[0] ? (~mag_x + OUT_W'(1)) : mag_x);
    assign shaped_y_next = dy_tag[1] ? '0 : (dy_tag[0] ? (~mag_y + OUT_W'(1)) : mag_y);

    assign en = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dx_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            shaped_x_reg <= shaped_x_next;
            shaped_y_reg <= shaped_y_next;
        end
    end

    assign s_tready = en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {shaped_y_reg, shaped_x_reg};

    // The two axis dividers must stay in lockstep.
    assert property (@(posedge clk) disable iff (!rst_n) dx_valid == dy_valid)
        else $error("axis dividers out of step");

    // The squared radius must follow every radius write.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=>
            (rad_sq_reg == RAD_SQ_W'(radius_reg) * RAD_SQ_W'(radius_reg)))
        else $error("squared radius does not match radius");

    // A held result must hold back the input side.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while output is stalled");

    // While stalled, the root stage must not advance.
    assert property (@(posedge clk) disable iff (!rst_n) !en |=> $stable(sq_valid))
        else $error("square root pipeline moved during a stall");

    // Outputs are clamped to plus or minus full scale.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((shaped_x_reg != 16'h8000) && (shaped_y_reg != 16'h8000)))
        else $error("output axis outside plus or minus one");

endmodule
